[hdl/mma_pkg.sv]
// shared types and codes for the 128-bit montgomery modular arithmetic unit
// no dependencies; imported by mma_digit and montgomery_mod_arith_128_top
`default_nettype none
package mma_pkg;

  // operation codes carried by each item
  localparam logic [1:0] MODE_MONT = 2'd0;
  localparam logic [1:0] MODE_PART = 2'd1;
  localparam logic [1:0] MODE_ADD  = 2'd2;
  localparam logic [1:0] MODE_NEG  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MOD_LOW  = 2'd0;
  localparam logic [1:0] REG_MOD_HIGH = 2'd1;
  localparam logic [1:0] REG_NEG_INV  = 2'd2;

  // configured modulus and quotient constant
  typedef struct packed {
    logic [127:0] modulus;
    logic [63:0]  neg_inv;
  } cfg_t;

  // item fields that ride alongside the product datapath
  typedef struct packed {
    logic [1:0]   mode;
    logic [127:0] a;
    logic [63:0]  b_high;
    logic [128:0] alt;
  } side_t;

endpackage
`default_nettype wire

[hdl/mma_digit.sv]
// one montgomery digit step as a seven-stage pipeline
// depends on mma_pkg (cfg_t, side_t, mode codes)
`default_nettype none
module mma_digit import mma_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         first,
  input  logic         in_vld,
  input  logic [63:0]  digit,
  input  logic [127:0] acc_in,
  input  side_t        side_in,
  input  cfg_t         cfg,
  output logic         out_vld,
  output logic [127:0] acc_out,
  output side_t        side_out
);

  logic [7:1]   vld;
  side_t        side [7:1];
  logic [127:0] acc1;
  logic [63:0]  pp1 [8];
  logic [192:0] acc2, acc3, acc4, acc5;
  logic [63:0]  qp0;
  logic [31:0]  qp1, qp2;
  logic [63:0]  q4;
  logic [63:0]  mp5 [8];
  logic [129:0] s6;
  logic [127:0] out7;

  logic [63:0]  pp_c [8];
  logic [63:0]  mp_c [8];
  logic [192:0] sum2;
  logic [193:0] t6;
  logic [63:0]  m01, m10;
  logic [129:0] mod_w, diff7;
  logic         red7, ge7;

  function automatic logic [63:0] a_part(input logic [127:0] v, input int k);
    a_part = {32'd0, v[32*k +: 32]};
  endfunction

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:1], in_vld};
    end
  end

  // digit times a partial products, 32x32 each
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 4; k++) begin
        pp_c[i*4+k] = {32'd0, digit[32*i +: 32]} * a_part(side_in.a, k);
      end
    end
  end

  // accumulate the partial products onto acc
  always_comb begin
    sum2 = {65'd0, acc1};
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 4; k++) begin
        sum2 = sum2 + ({129'd0, pp1[i*4+k]} << (32 * (i + k)));
      end
    end
  end

  // low-half quotient cross products
  assign m01 = {32'd0, acc2[31:0]} * {32'd0, cfg.neg_inv[63:32]};
  assign m10 = {32'd0, acc2[63:32]} * {32'd0, cfg.neg_inv[31:0]};

  // quotient times modulus partial products
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 4; k++) begin
        mp_c[i*4+k] = {32'd0, q4[32*i +: 32]} * {32'd0, cfg.modulus[32*k +: 32]};
      end
    end
  end

  // add q*m, low 64 bits come out zero
  always_comb begin
    t6 = {1'b0, acc5};
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 4; k++) begin
        t6 = t6 + ({130'd0, mp5[i*4+k]} << (32 * (i + k)));
      end
    end
  end

  // conditional subtract of the modulus
  assign mod_w = {2'b00, cfg.modulus};
  assign red7  = first || (side[6].mode == MODE_MONT);
  assign ge7   = (s6 >= mod_w);
  assign diff7 = s6 - mod_w;

  // datapath stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= side_in;
      for (int n = 2; n <= 7; n++) begin
        side[n] <= side[n-1];
      end
      acc1 <= acc_in;
      pp1  <= pp_c;
      acc2 <= sum2;
      acc3 <= acc2;
      qp0  <= {32'd0, acc2[31:0]} * {32'd0, cfg.neg_inv[31:0]};
      qp1  <= m01[31:0];
      qp2  <= m10[31:0];
      acc4 <= acc3;
      q4   <= qp0 + {qp1 + qp2, 32'd0};
      acc5 <= acc4;
      mp5  <= mp_c;
      s6   <= t6[193:64];
      out7 <= (red7 && ge7) ? diff7[127:0] : s6[127:0];
    end
  end

  assign out_vld  = vld[7];
  assign acc_out  = out7;
  assign side_out = side[7];

endmodule
`default_nettype wire

[hdl/montgomery_mod_arith_128_top.sv]
// throughput: one item per cycle unless the result is stalled; two seven-stage digit pipelines plus an output register
// a result stall while the result is valid freezes the whole pipeline and stalls the input in the same cycle
// reset clears all valid bits and the modulus and quotient constant registers
// depends on mma_pkg and mma_digit
`default_nettype none
module montgomery_mod_arith_128_top import mma_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] a_low,
  input  logic [63:0] a_high,
  input  logic [63:0] b_low,
  input  logic [63:0] b_high,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] result_low,
  output logic [63:0] result_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t         cfg;
  logic         adv;
  side_t        side0, side_d0, side_d1;
  logic         vld_d0, vld_d1;
  logic [127:0] acc_d0, acc_d1;
  logic [127:0] a_w, b_w, neg_w;
  logic [128:0] sub_w, mod_w;
  logic [127:0] fin;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOD_LOW:  cfg.modulus[63:0]   <= cfg_data;
        REG_MOD_HIGH: cfg.modulus[127:64] <= cfg_data;
        REG_NEG_INV:  cfg.neg_inv         <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the result is held
  assign adv      = !res_valid || !res_stall;
  assign op_stall = !adv;

  // entry: add or negate goes in the side field
  assign a_w   = {a_high, a_low};
  assign b_w   = {b_high, b_low};
  assign neg_w = cfg.modulus - a_w;
  always_comb begin
    side0.mode   = mode;
    side0.a      = a_w;
    side0.b_high = b_high;
    side0.alt    = (mode == MODE_NEG) ? {1'b0, neg_w} : ({1'b0, a_w} + {1'b0, b_w});
  end

  mma_digit u_digit0 (
    .clk(clk), .rst(rst), .adv(adv), .first(1'b1),
    .in_vld(op_valid), .digit(b_low), .acc_in(128'd0), .side_in(side0),
    .cfg(cfg), .out_vld(vld_d0), .acc_out(acc_d0), .side_out(side_d0)
  );

  mma_digit u_digit1 (
    .clk(clk), .rst(rst), .adv(adv), .first(1'b0),
    .in_vld(vld_d0), .digit(side_d0.b_high), .acc_in(acc_d0), .side_in(side_d0),
    .cfg(cfg), .out_vld(vld_d1), .acc_out(acc_d1), .side_out(side_d1)
  );

  // final select, modular add reduces here
  assign mod_w = {1'b0, cfg.modulus};
  assign sub_w = side_d1.alt - mod_w;
  always_comb begin
    case (side_d1.mode)
      MODE_ADD: fin = (side_d1.alt >= mod_w) ? sub_w[127:0] : side_d1.alt[127:0];
      MODE_NEG: fin = side_d1.alt[127:0];
      default:  fin = acc_d1;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= vld_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {result_high, result_low} <= fin;
    end
  end

  // checks
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    ($past(vld_d1) && !$past(op_stall) && !$past(rst)) |-> res_valid)
    else $error("item lost between digit pipeline and output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ($past(res_valid) && $past(res_stall) && !$past(rst)) |-> $stable(acc_d1))
    else $error("pipeline moved during result stall");

endmodule
`default_nettype wire
